// ===== hw/rtl/scp_pkg.sv =====
`default_nettype none

package scp_pkg;

	localparam int unsigned WholeW = 16;
	localparam int unsigned FracW  = 14;
	localparam int unsigned CountW = 3;

	localparam logic [WholeW-1:0] WHOLE_MAX = 16'd65535;
	localparam logic [FracW-1:0]  FRAC_MAX  = 14'd9999;
	localparam logic [CountW-1:0] COUNT_MAX = 3'd7;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ETX   = 8'h03;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_QUERY = 8'h3F;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_L_LO  = 8'h6C;
	localparam logic [7:0] CH_L_UP  = 8'h4C;
	localparam logic [7:0] CH_K_LO  = 8'h6B;
	localparam logic [7:0] CH_K_UP  = 8'h4B;
	localparam logic [7:0] CH_B_LO  = 8'h62;
	localparam logic [7:0] CH_B_UP  = 8'h42;
	localparam logic [7:0] CH_G_LO  = 8'h67;
	localparam logic [7:0] CH_G_UP  = 8'h47;

	localparam logic [7:0] STATUS_REQ  = 8'h30;
	localparam logic [7:0] STATUS_MORE = 8'h40;

	localparam int unsigned PAddrW = 3;
	localparam logic [PAddrW-1:0] REG_MODE = 3'd0;

	typedef enum logic [3:0] {
		ERR_OK         = 4'd0,
		ERR_STATUS_ONE = 4'd1,
		ERR_STATUS_TWO = 4'd2,
		ERR_STATUS_THR = 4'd3,
		ERR_TERM       = 4'd4,
		ERR_NO_POINT   = 4'd5,
		ERR_UNITS      = 4'd6,
		ERR_CRLF       = 4'd7,
		ERR_UNRECOG    = 4'd8
	} err_code_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_INT,
		PH_FRAC,
		PH_UNIT_L,
		PH_UNIT_K,
		PH_CR1,
		PH_LF1,
		PH_PREFIX,
		PH_ST1,
		PH_ST2,
		PH_ST3,
		PH_CR2,
		PH_ETX
	} phase_t;

	typedef struct packed {
		logic [WholeW-1:0] weight_whole;
		logic [FracW-1:0]  weight_fraction;
		logic [CountW-1:0] fraction_digit_count;
		logic              units_kg;
		logic [7:0]        status_one;
		logic [7:0]        status_two;
		logic [7:0]        status_three;
		logic              status_three_present;
		logic              extended_form;
		logic [3:0]        error_code;
	} result_t;

	typedef struct packed {
		logic valid;
		logic take;
	} stage_ctl_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic status_ok(input logic [7:0] b);
		return (b & STATUS_REQ) == STATUS_REQ;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/scale_response_parser_top.sv =====
// Serial scale reply parser.
// Received bytes enter on the rx channel (rx_valid, rx_stall, rx_byte), one
// item per byte. An LF outside a frame opens a frame, and one result item per
// frame leaves on the res channel (res_valid, res_stall and the result fields)
// at ETX, at the first framing error, or at an unrecognized-command reply.
// Bytes pass through an input register and then a single stage of parsing
// logic into the result register. One byte per cycle is sustained while no
// result waits on res_stall, with the parse state and accumulators updated
// for each byte as it is taken.
// When res_stall holds a waiting result, at most one more byte is taken into
// the input register and then rx_stall rises until the result is taken.
// The response_mode register lies at byte address 0 of the APB port; write it
// only while no frame result is pending, as the block does not enforce this.
// Reset returns the parser to idle, clears all accumulators and results, and
// clears response_mode to weight mode.
`default_nettype none

module scale_response_parser_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [scp_pkg::PAddrW-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  wire logic                       rx_valid,
	output logic                            rx_stall,
	input  wire logic [7:0]                 rx_byte,
	output logic                            res_valid,
	input  wire logic                       res_stall,
	output logic [15:0]                     weight_whole,
	output logic [13:0]                     weight_fraction,
	output logic [2:0]                      fraction_digit_count,
	output logic                            units_kg,
	output logic [7:0]                      status_one,
	output logic [7:0]                      status_two,
	output logic [7:0]                      status_three,
	output logic                            status_three_present,
	output logic                            extended_form,
	output logic [3:0]                      error_code
);
	import scp_pkg::*;

	logic       mode;
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	stage_ctl_t ctl;
	result_t    res;

	scp_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.response_mode (mode)
	);

	assign rx_stall = valid_s1 && !ctl.take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	scp_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.response_mode (mode),
		.in_valid      (valid_s1),
		.in_byte       (rx_byte_s1),
		.res_stall     (res_stall),
		.ctl           (ctl),
		.res_valid     (res_valid),
		.res           (res)
	);

	assign weight_whole         = res.weight_whole;
	assign weight_fraction      = res.weight_fraction;
	assign fraction_digit_count = res.fraction_digit_count;
	assign units_kg             = res.units_kg;
	assign status_one           = res.status_one;
	assign status_two           = res.status_two;
	assign status_three         = res.status_three;
	assign status_three_present = res.status_three_present;
	assign extended_form        = res.extended_form;
	assign error_code           = res.error_code;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	a_held_item_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !ctl.take) |=> (valid_s1 && $stable(rx_byte_s1)))
		else $error("waiting item lost or changed in the input register");

	a_no_take_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |-> !ctl.take)
		else $error("parser advanced while a result was blocked");

	a_take_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.take |-> ctl.valid)
		else $error("parser advanced without an item");

endmodule

`default_nettype wire

// ===== hw/rtl/scp_cfg.sv =====
`default_nettype none

module scp_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [scp_pkg::PAddrW-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output logic                            response_mode
);
	import scp_pkg::*;

	logic mode_q;
	logic hit;

	assign hit    = (paddr[PAddrW-1:2] == REG_MODE[PAddrW-1:2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && hit) begin
			mode_q <= pwdata[0];
		end
	end

	assign prdata        = hit ? {31'd0, mode_q} : 32'd0;
	assign response_mode = mode_q;

endmodule

`default_nettype wire

// ===== hw/rtl/scp_parser.sv =====
`default_nettype none

module scp_parser (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               response_mode,
	input  wire logic               in_valid,
	input  wire logic [7:0]         in_byte,
	input  wire logic               res_stall,
	output scp_pkg::stage_ctl_t     ctl,
	output logic                    res_valid,
	output scp_pkg::result_t        res
);
	import scp_pkg::*;

	phase_t phase_q, phase_d;

	logic [WholeW-1:0] whole_q;
	logic [FracW-1:0]  frac_q;
	logic [CountW-1:0] count_q;
	logic              units_q;
	logic [7:0]        st1_q, st2_q, st3_q;
	logic              st3_exp_q;
	logic              prefix_q;
	logic [1:0]        fault_q;

	logic       res_valid_q;
	result_t    res_q;

	logic       take;
	logic       emit;
	err_code_t  code;
	logic       do_clear, do_int, do_frac, do_units, do_prefix;
	logic       do_st1, do_st2, do_st3;
	logic       digit;

	logic [19:0]       int_sum;
	logic [17:0]       frac_sum;
	logic [WholeW-1:0] int_next;
	logic [FracW-1:0]  frac_next;

	assign take  = in_valid && (!res_valid_q || !res_stall);
	assign digit = is_digit(in_byte);

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (in_byte == CH_LF) phase_d = response_mode ? PH_PREFIX : PH_INT;
			end
			PH_INT: begin
				if (digit) phase_d = PH_INT;
				else if (in_byte == CH_POINT) phase_d = PH_FRAC;
				else phase_d = PH_IDLE;
			end
			PH_FRAC: begin
				if (digit) phase_d = PH_FRAC;
				else if (in_byte == CH_L_LO || in_byte == CH_L_UP) phase_d = PH_UNIT_L;
				else if (in_byte == CH_K_LO || in_byte == CH_K_UP) phase_d = PH_UNIT_K;
				else phase_d = PH_IDLE;
			end
			PH_UNIT_L: begin
				phase_d = (in_byte == CH_B_LO || in_byte == CH_B_UP) ? PH_CR1 : PH_IDLE;
			end
			PH_UNIT_K: begin
				phase_d = (in_byte == CH_G_LO || in_byte == CH_G_UP) ? PH_CR1 : PH_IDLE;
			end
			PH_CR1:    phase_d = (in_byte == CH_CR) ? PH_LF1 : PH_IDLE;
			PH_LF1:    phase_d = (in_byte == CH_LF) ? PH_PREFIX : PH_IDLE;
			PH_PREFIX: begin
				if (in_byte == CH_S) phase_d = PH_ST1;
				else if (in_byte == CH_QUERY && response_mode) phase_d = PH_IDLE;
				else phase_d = PH_ST2;
			end
			PH_ST1:    phase_d = PH_ST2;
			PH_ST2:    phase_d = ((in_byte & STATUS_MORE) != 8'd0) ? PH_ST3 : PH_CR2;
			PH_ST3:    phase_d = PH_CR2;
			PH_CR2:    phase_d = (in_byte == CH_CR) ? PH_ETX : PH_IDLE;
			PH_ETX:    phase_d = PH_IDLE;
			default:   phase_d = PH_IDLE;
		endcase
	end

	always_comb begin
		emit      = 1'b0;
		code      = ERR_OK;
		do_clear  = 1'b0;
		do_int    = 1'b0;
		do_frac   = 1'b0;
		do_units  = 1'b0;
		do_prefix = 1'b0;
		do_st1    = 1'b0;
		do_st2    = 1'b0;
		do_st3    = 1'b0;
		unique case (phase_q)
			PH_IDLE: do_clear = (in_byte == CH_LF);
			PH_INT: begin
				if (digit) begin
					do_int = 1'b1;
				end else if (in_byte != CH_POINT) begin
					emit = 1'b1;
					code = (in_byte == CH_QUERY) ? ERR_UNRECOG : ERR_NO_POINT;
				end
			end
			PH_FRAC: begin
				if (digit) begin
					do_frac = 1'b1;
				end else if (!(in_byte == CH_L_LO || in_byte == CH_L_UP ||
						in_byte == CH_K_LO || in_byte == CH_K_UP)) begin
					emit = 1'b1;
					code = ERR_UNITS;
				end
			end
			PH_UNIT_L: begin
				if (in_byte == CH_B_LO || in_byte == CH_B_UP) begin
					do_units = 1'b1;
				end else begin
					emit = 1'b1;
					code = ERR_UNITS;
				end
			end
			PH_UNIT_K: begin
				if (in_byte == CH_G_LO || in_byte == CH_G_UP) begin
					do_units = 1'b1;
				end else begin
					emit = 1'b1;
					code = ERR_UNITS;
				end
			end
			PH_CR1: begin
				emit = (in_byte != CH_CR);
				code = ERR_CRLF;
			end
			PH_LF1: begin
				emit = (in_byte != CH_LF);
				code = ERR_CRLF;
			end
			PH_PREFIX: begin
				if (in_byte == CH_S) begin
					do_prefix = 1'b1;
				end else if (in_byte == CH_QUERY && response_mode) begin
					emit = 1'b1;
					code = ERR_UNRECOG;
				end else begin
					do_st1 = 1'b1;
				end
			end
			PH_ST1: do_st1 = 1'b1;
			PH_ST2: do_st2 = 1'b1;
			PH_ST3: do_st3 = 1'b1;
			PH_CR2: begin
				emit = (in_byte != CH_CR);
				code = ERR_TERM;
			end
			PH_ETX: begin
				emit = 1'b1;
				code = (in_byte == CH_ETX) ? err_code_t'({2'd0, fault_q}) : ERR_TERM;
			end
			default: emit = 1'b0;
		endcase
	end

	assign int_sum   = ({4'd0, whole_q} << 3) + ({4'd0, whole_q} << 1) + {16'd0, in_byte[3:0]};
	assign int_next  = (int_sum > {4'd0, WHOLE_MAX}) ? WHOLE_MAX : int_sum[WholeW-1:0];
	assign frac_sum  = ({4'd0, frac_q} << 3) + ({4'd0, frac_q} << 1) + {14'd0, in_byte[3:0]};
	assign frac_next = (frac_sum > {4'd0, FRAC_MAX}) ? FRAC_MAX : frac_sum[FracW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			whole_q   <= '0;
			frac_q    <= '0;
			count_q   <= '0;
			units_q   <= 1'b0;
			st1_q     <= 8'd0;
			st2_q     <= 8'd0;
			st3_q     <= 8'd0;
			st3_exp_q <= 1'b0;
			prefix_q  <= 1'b0;
			fault_q   <= 2'd0;
		end else if (take) begin
			phase_q <= phase_d;
			if (do_clear) begin
				whole_q   <= '0;
				frac_q    <= '0;
				count_q   <= '0;
				units_q   <= 1'b0;
				st1_q     <= 8'd0;
				st2_q     <= 8'd0;
				st3_q     <= 8'd0;
				st3_exp_q <= 1'b0;
				prefix_q  <= 1'b0;
				fault_q   <= 2'd0;
			end
			if (do_int) whole_q <= int_next;
			if (do_frac) begin
				frac_q <= frac_next;
				if (count_q != COUNT_MAX) count_q <= count_q + 3'd1;
			end
			if (do_units) units_q <= (phase_q == PH_UNIT_K);
			if (do_prefix) prefix_q <= 1'b1;
			if (do_st1) begin
				st1_q <= in_byte;
				if (!status_ok(in_byte)) fault_q <= 2'd1;
			end
			if (do_st2) begin
				st2_q <= in_byte;
				if (!status_ok(in_byte)) fault_q <= 2'd2;
				if ((in_byte & STATUS_MORE) != 8'd0) st3_exp_q <= 1'b1;
			end
			if (do_st3) begin
				st3_q <= in_byte;
				if (!status_ok(in_byte)) fault_q <= 2'd3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (take && emit) begin
			res_q.weight_whole         <= whole_q;
			res_q.weight_fraction      <= frac_q;
			res_q.fraction_digit_count <= count_q;
			res_q.units_kg             <= units_q;
			res_q.status_one           <= st1_q;
			res_q.status_two           <= st2_q;
			res_q.status_three         <= st3_q;
			res_q.status_three_present <= st3_exp_q;
			res_q.extended_form        <= prefix_q;
			res_q.error_code           <= code;
		end
	end

	assign ctl.valid = in_valid;
	assign ctl.take  = take;
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import scp_pkg::*;

	localparam logic [7:0] DIGIT_ZERO = 8'h30;
	localparam logic [7:0] DIGIT_NINE = 8'h39;
	localparam logic [7:0] FLUSH_BYTE = 8'h78;
	localparam int unsigned BYTES_PER_BLOCK = 220;

	typedef struct {
		logic    mode;
		string   text;
		bit      typed;
		result_t want;
	} reply_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PAddrW-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                rx_valid;
	logic                rx_stall;
	logic [7:0]          rx_byte;
	logic                res_valid;
	logic                res_stall;
	logic [15:0]         weight_whole;
	logic [13:0]         weight_fraction;
	logic [2:0]          fraction_digit_count;
	logic                units_kg;
	logic [7:0]          status_one;
	logic [7:0]          status_two;
	logic [7:0]          status_three;
	logic                status_three_present;
	logic                extended_form;
	logic [3:0]          error_code;

	scale_response_parser_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.weight_whole(weight_whole),
		.weight_fraction(weight_fraction),
		.fraction_digit_count(fraction_digit_count),
		.units_kg(units_kg),
		.status_one(status_one),
		.status_two(status_two),
		.status_three(status_three),
		.status_three_present(status_three_present),
		.extended_form(extended_form),
		.error_code(error_code)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Parser state as the block should hold it.
	phase_t      reply_phase = PH_IDLE;
	logic        mode_reg = 1'b0;
	logic [15:0] whole_acc;
	logic [13:0] frac_acc;
	logic [2:0]  frac_digits;
	logic        kg_seen;
	logic [7:0]  stat1;
	logic [7:0]  stat2;
	logic [7:0]  stat3;
	logic        stat3_due;
	logic        s_prefix;
	err_code_t   stat_fault;
	result_t     frame_result;

	result_t     pending_results[$];
	reply_row_t  reply_table[$];
	int unsigned mismatch_count = 0;
	int unsigned parsed_bytes = 0;
	int unsigned send_gap_pct = 15;
	int unsigned res_stall_pct = 87;

	function automatic void clear_reply();
		whole_acc = '0;
		frac_acc = '0;
		frac_digits = '0;
		kg_seen = 1'b0;
		stat1 = '0;
		stat2 = '0;
		stat3 = '0;
		stat3_due = 1'b0;
		s_prefix = 1'b0;
		stat_fault = ERR_OK;
	endfunction

	function automatic bit end_reply(input err_code_t code);
		frame_result = '{weight_whole: whole_acc, weight_fraction: frac_acc,
			fraction_digit_count: frac_digits, units_kg: kg_seen, status_one: stat1,
			status_two: stat2, status_three: stat3, status_three_present: stat3_due,
			extended_form: s_prefix, error_code: code};
		reply_phase = PH_IDLE;
		return 1'b1;
	endfunction

	function automatic void take_first_status(input logic [7:0] b);
		stat1 = b;
		if ((b & STATUS_REQ) != STATUS_REQ)
			stat_fault = ERR_STATUS_ONE;
		reply_phase = PH_ST2;
	endfunction

	// Returns 1 when the byte closes a frame; the result is left in frame_result.
	function automatic bit parse_reply_byte(input logic [7:0] b);
		int unsigned acc;
		bit digit;
		digit = (b >= DIGIT_ZERO) && (b <= DIGIT_NINE);
		case (reply_phase)
			PH_IDLE: begin
				if (b == CH_LF) begin
					clear_reply();
					reply_phase = mode_reg ? PH_PREFIX : PH_INT;
				end
			end
			PH_INT: begin
				if (digit) begin
					acc = whole_acc * 32'd10 + (b - DIGIT_ZERO);
					whole_acc = (acc > WHOLE_MAX) ? WHOLE_MAX : acc[15:0];
				end else if (b == CH_POINT) begin
					reply_phase = PH_FRAC;
				end else if (b == CH_QUERY) begin
					return end_reply(ERR_UNRECOG);
				end else begin
					return end_reply(ERR_NO_POINT);
				end
			end
			PH_FRAC: begin
				if (digit) begin
					acc = frac_acc * 32'd10 + (b - DIGIT_ZERO);
					frac_acc = (acc > FRAC_MAX) ? FRAC_MAX : acc[13:0];
					if (frac_digits != COUNT_MAX)
						frac_digits++;
				end else if (b == CH_L_LO || b == CH_L_UP) begin
					reply_phase = PH_UNIT_L;
				end else if (b == CH_K_LO || b == CH_K_UP) begin
					reply_phase = PH_UNIT_K;
				end else begin
					return end_reply(ERR_UNITS);
				end
			end
			PH_UNIT_L: begin
				if (b != CH_B_LO && b != CH_B_UP)
					return end_reply(ERR_UNITS);
				kg_seen = 1'b0;
				reply_phase = PH_CR1;
			end
			PH_UNIT_K: begin
				if (b != CH_G_LO && b != CH_G_UP)
					return end_reply(ERR_UNITS);
				kg_seen = 1'b1;
				reply_phase = PH_CR1;
			end
			PH_CR1: begin
				if (b != CH_CR)
					return end_reply(ERR_CRLF);
				reply_phase = PH_LF1;
			end
			PH_LF1: begin
				if (b != CH_LF)
					return end_reply(ERR_CRLF);
				reply_phase = PH_PREFIX;
			end
			PH_PREFIX: begin
				if (b == CH_S) begin
					s_prefix = 1'b1;
					reply_phase = PH_ST1;
				end else if (b == CH_QUERY && mode_reg) begin
					return end_reply(ERR_UNRECOG);
				end else begin
					take_first_status(b);
				end
			end
			PH_ST1: take_first_status(b);
			PH_ST2: begin
				stat2 = b;
				if ((b & STATUS_REQ) != STATUS_REQ)
					stat_fault = ERR_STATUS_TWO;
				if ((b & STATUS_MORE) != 0) begin
					stat3_due = 1'b1;
					reply_phase = PH_ST3;
				end else begin
					reply_phase = PH_CR2;
				end
			end
			PH_ST3: begin
				stat3 = b;
				if ((b & STATUS_REQ) != STATUS_REQ)
					stat_fault = ERR_STATUS_THR;
				reply_phase = PH_CR2;
			end
			PH_CR2: begin
				if (b != CH_CR)
					return end_reply(ERR_TERM);
				reply_phase = PH_ETX;
			end
			PH_ETX: begin
				if (b == CH_ETX)
					return end_reply(stat_fault);
				return end_reply(ERR_TERM);
			end
			default: reply_phase = PH_IDLE;
		endcase
		return 1'b0;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				$error("result item arrived with no frame pending");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("weight_whole", want.weight_whole, weight_whole);
				check_field("weight_fraction", want.weight_fraction, weight_fraction);
				check_field("fraction_digit_count", want.fraction_digit_count,
					fraction_digit_count);
				check_field("units_kg", want.units_kg, units_kg);
				check_field("status_one", want.status_one, status_one);
				check_field("status_two", want.status_two, status_two);
				check_field("status_three", want.status_three, status_three);
				check_field("status_three_present", want.status_three_present,
					status_three_present);
				check_field("extended_form", want.extended_form, extended_form);
				check_field("error_code", want.error_code, error_code);
			end
		end
		res_stall <= ($urandom_range(99) < res_stall_pct);
	end

	task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
			input result_t typed_want = '0);
		while ($urandom_range(99) < send_gap_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (rx_stall);
		if (reply_phase != PH_IDLE || b == CH_LF)
			parsed_bytes++;
		if (parse_reply_byte(b))
			pending_results.push_back(typed ? typed_want : frame_result);
	endtask

	task automatic drain_results(input int unsigned settle);
		rx_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	// Any frame still open is closed first, so the new mode is never seen mid-frame.
	task automatic set_mode(input logic value);
		while (reply_phase != PH_IDLE)
			send_byte(FLUSH_BYTE);
		drain_results(4);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_MODE;
		pwdata <= {31'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		mode_reg = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[0] !== value) begin
			$error("response_mode: expected %0d, got %0d", value, prdata[0]);
			mismatch_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] random_status();
		logic [7:0] st;
		st = 8'($urandom_range(255));
		if ($urandom_range(9) != 0)
			st |= STATUS_REQ;
		return st;
	endfunction

	task automatic send_random_reply();
		logic [7:0] frame[$];
		logic [7:0] st;
		logic [7:0] b;
		int unsigned body_start;
		int unsigned idx;
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 8) begin
			repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(0, 2)) begin
				do
					b = 8'($urandom_range(255));
				while (b == CH_LF);
				frame.push_back(b);
			end
			frame.push_back(CH_LF);
			body_start = frame.size();
			if (!mode_reg) begin
				repeat ($urandom_range(9) == 0 ? $urandom_range(5, 8) : $urandom_range(0, 4))
					frame.push_back(DIGIT_ZERO + 8'($urandom_range(9)));
				frame.push_back(roll < 11 ? CH_QUERY : CH_POINT);
				repeat ($urandom_range(9) == 0 ? $urandom_range(5, 9) : $urandom_range(0, 4))
					frame.push_back(DIGIT_ZERO + 8'($urandom_range(9)));
				if ($urandom_range(1)) begin
					frame.push_back($urandom_range(1) ? CH_L_LO : CH_L_UP);
					frame.push_back($urandom_range(1) ? CH_B_LO : CH_B_UP);
				end else begin
					frame.push_back($urandom_range(1) ? CH_K_LO : CH_K_UP);
					frame.push_back($urandom_range(1) ? CH_G_LO : CH_G_UP);
				end
				frame.push_back(CH_CR);
				frame.push_back(CH_LF);
			end else if (roll < 12) begin
				frame.push_back(CH_QUERY);
			end
			if ($urandom_range(1))
				frame.push_back(CH_S);
			frame.push_back(random_status());
			st = random_status();
			frame.push_back(st);
			if ((st & STATUS_MORE) != 0)
				frame.push_back(random_status());
			frame.push_back(CH_CR);
			frame.push_back(CH_ETX);
			if (roll >= 85) begin
				idx = $urandom_range(body_start, frame.size() - 1);
				if (roll >= 95) begin
					while (frame.size() > idx)
						void'(frame.pop_back());
				end else begin
					frame[idx] = 8'($urandom_range(255));
				end
			end
		end
		foreach (frame[i])
			send_byte(frame[i]);
	endtask

	function automatic void add_row(input logic mode, input string text, input bit typed,
			input result_t want);
		reply_row_t row;
		row.mode = mode;
		row.text = text;
		row.typed = typed;
		row.want = want;
		reply_table.push_back(row);
	endfunction

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rx_valid = 1'b0;
		rx_byte = '0;
		res_stall = 1'b0;
		clear_reply();

		add_row(1'b0, "ab\r\n?", 1'b1, '{error_code: ERR_UNRECOG, default: '0});
		add_row(1'b0, "\n\n", 1'b1, '{error_code: ERR_NO_POINT, default: '0});
		add_row(1'b0, "\n99999.12345678kg\r\nS0p?\r\003", 1'b1,
			'{weight_whole: WHOLE_MAX, weight_fraction: FRAC_MAX,
			fraction_digit_count: COUNT_MAX, units_kg: 1'b1, status_one: 8'h30,
			status_two: 8'h70, status_three: 8'h3F, status_three_present: 1'b1,
			extended_form: 1'b1, error_code: ERR_OK});
		add_row(1'b0, "\n.LB\r\n\377\017\r\003", 1'b1,
			'{status_one: 8'hFF, status_two: 8'h0F, error_code: ERR_STATUS_TWO,
			default: '0});
		add_row(1'b0, "\n1.5Kx", 1'b0, '0);
		add_row(1'b0, "\n2.x", 1'b0, '0);
		add_row(1'b0, "\n3.Lx", 1'b0, '0);
		add_row(1'b0, "\n4.kGx", 1'b0, '0);
		add_row(1'b0, "\n7.lb\r\r", 1'b0, '0);
		add_row(1'b0, "\n5.Kg\r\n\001@\001\r\003", 1'b0, '0);
		add_row(1'b0, "\n6.lB\r\n00x", 1'b0, '0);
		add_row(1'b0, "\n0.lb\r\n00\r\n", 1'b0, '0);
		add_row(1'b0, "\n.lb\r\n?0\r\003", 1'b0, '0);
		add_row(1'b1, "\n?", 1'b1, '{error_code: ERR_UNRECOG, default: '0});
		add_row(1'b1, "\nS?0\r\003", 1'b0, '0);
		add_row(1'b1, "\n5\177\001\r\003", 1'b0, '0);
		add_row(1'b1, "\n\0010\r\003", 1'b0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (reply_table[r]) begin
			if (reply_table[r].mode != mode_reg)
				set_mode(reply_table[r].mode);
			for (int i = 0; i < reply_table[r].text.len(); i++)
				send_byte(reply_table[r].text[i], reply_table[r].typed, reply_table[r].want);
		end

		for (int p = 0; p < 3; p++) begin
			send_gap_pct = (p == 0) ? 15 : (p == 1) ? 87 : 0;
			res_stall_pct = (p == 0) ? 87 : (p == 1) ? 15 : 0;
			for (int m = 0; m < 2; m++) begin
				int unsigned goal;
				set_mode(m == 0 ? 1'b0 : 1'b1);
				goal = parsed_bytes + BYTES_PER_BLOCK;
				while (parsed_bytes < goal) begin
					if ($urandom_range(199) == 0)
						drain_results(0);
					send_random_reply();
				end
			end
		end

		while (reply_phase != PH_IDLE)
			send_byte(FLUSH_BYTE);
		drain_results(8);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
